>>> rtl/bdmc_pkg.sv
// ----------------------------------------------------------------------------
// bdmc_pkg
// Shared types and constants of the button debounce and mode control block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdmc_pkg;

    localparam int BUTTON_COUNT = 6;

    localparam int BTN_WARM   = 0;
    localparam int BTN_COOK   = 1;
    localparam int BTN_ADJUST = 2;
    localparam int BTN_MENU   = 3;
    localparam int BTN_HOUR   = 4;
    localparam int BTN_MINUTE = 5;

    localparam int DELAY_W    = 16;
    localparam int STEP_W     = 16;
    localparam int MENU_W     = 4;
    localparam int PRESET_W   = 32;
    localparam int NOW_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RESET = 16'd50;
    localparam logic [MENU_W-1:0]  MENU_TOP_RESET       = 4'd9;
    localparam logic [STEP_W-1:0]  HOUR_STEP_RESET      = 16'd3600;
    localparam logic [STEP_W-1:0]  MINUTE_STEP_RESET    = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_DELAY = 2'd0,
        CFG_MENU_TOP       = 2'd1,
        CFG_HOUR_STEP      = 2'd2,
        CFG_MINUTE_STEP    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic stable;
        logic press;
    } t_deb_status;

endpackage

`default_nettype wire

>>> rtl/bdmc_debounce.sv
// ----------------------------------------------------------------------------
// bdmc_debounce
// Debouncer for one button: tracks the previous raw level, the time of the
// last raw change and the stable level, and flags a newly stable press.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmc_debounce #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_raw,
    input  wire logic [TIME_BITS-1:0]           i_now,
    input  wire logic [bdmc_pkg::DELAY_W-1:0]   i_delay,
    output bdmc_pkg::t_deb_status               o_status
);

    logic                 r_stable;
    logic                 r_prev;
    logic [TIME_BITS-1:0] r_stamp;

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_fire;

    // A raw change restarts the timer, so it can never fire in the same scan.
    assign w_elapsed = i_now - r_stamp;
    assign w_fire    = (i_raw == r_prev) && (w_elapsed > TIME_BITS'(i_delay))
                       && (i_raw != r_stable);

    assign o_status.stable = w_fire ? i_raw : r_stable;
    assign o_status.press  = w_fire && !i_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_prev   <= 1'b1;
            r_stamp  <= '0;
        end else if (i_en) begin
            r_prev <= i_raw;
            if (i_raw != r_prev) begin
                r_stamp <= i_now;
            end
            if (w_fire) begin
                r_stable <= i_raw;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/button_debounce_mode_control.sv
// Datapath: a scan is accepted into the input register, and its result moves into the output register.
// Throughput: one scan per cycle unless the output stalls; the output register
// lets a new scan enter while the previous result still waits to be taken.
// Reset: synchronous, active low; debouncers return to released, modes off,
// menu and preset to zero, configuration registers to their defaults.
// ----------------------------------------------------------------------------
// button_debounce_mode_control
// Six-button debouncer with cooking, warming, adjust and menu mode control
// and a saturating preset time.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_mode_control #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bdmc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [bdmc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    // [5:0] button_levels, [37:6] now_ms, [39:38] zero
    input  wire logic [bdmc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] cooking_on, [1] warming_on, [2] adjust_on, [6:3] menu_number,
    // [38:7] preset_seconds, [44:39] stable_levels, [47:45] zero
    output      logic [bdmc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int NB = bdmc_pkg::BUTTON_COUNT;

    logic [bdmc_pkg::DELAY_W-1:0]  r_debounce_delay;
    logic [bdmc_pkg::MENU_W-1:0]   r_menu_top;
    logic [bdmc_pkg::STEP_W-1:0]   r_hour_step;
    logic [bdmc_pkg::STEP_W-1:0]   r_minute_step;

    logic                          r_in_valid;
    logic [NB-1:0]                 r_in_levels;
    logic [bdmc_pkg::NOW_W-1:0]    r_in_now;

    logic [NB-1:0]                 r_pending;
    logic                          r_cook;
    logic                          r_warm;
    logic                          r_adjust;
    logic [bdmc_pkg::MENU_W-1:0]   r_menu;
    logic [bdmc_pkg::PRESET_W-1:0] r_preset;

    logic                          r_out_valid;
    logic [bdmc_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [NB-1:0]                 n_pending;
    logic                          n_cook;
    logic                          n_warm;
    logic                          n_adjust;
    logic [bdmc_pkg::MENU_W-1:0]   n_menu;
    logic [bdmc_pkg::PRESET_W-1:0] n_preset;

    logic                          w_advance;
    bdmc_pkg::t_deb_status         w_status [NB];
    logic [NB-1:0]                 w_stable;
    logic [NB-1:0]                 w_press;

    logic [bdmc_pkg::PRESET_W:0]   w_sum_h;
    logic [bdmc_pkg::PRESET_W:0]   w_sum_m;
    logic [bdmc_pkg::PRESET_W:0]   w_sum_hm;
    logic [bdmc_pkg::STEP_W:0]     w_step_hm;
    logic [bdmc_pkg::PRESET_W-1:0] w_sat_h;
    logic [bdmc_pkg::PRESET_W-1:0] w_sat_m;
    logic [bdmc_pkg::PRESET_W-1:0] w_sat_hm;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_delay <= bdmc_pkg::DEBOUNCE_DELAY_RESET;
            r_menu_top       <= bdmc_pkg::MENU_TOP_RESET;
            r_hour_step      <= bdmc_pkg::HOUR_STEP_RESET;
            r_minute_step    <= bdmc_pkg::MINUTE_STEP_RESET;
        end else if (i_cfg_we) begin
            case (bdmc_pkg::t_cfg_index'(i_cfg_index))
                bdmc_pkg::CFG_DEBOUNCE_DELAY: r_debounce_delay <= i_cfg_data;
                bdmc_pkg::CFG_MENU_TOP: begin
                    r_menu_top <= i_cfg_data[bdmc_pkg::MENU_W-1:0];
                end
                bdmc_pkg::CFG_HOUR_STEP:      r_hour_step <= i_cfg_data;
                bdmc_pkg::CFG_MINUTE_STEP:    r_minute_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_levels <= s_axis_tdata[NB-1:0];
            r_in_now    <= s_axis_tdata[NB +: bdmc_pkg::NOW_W];
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_deb
        bdmc_debounce #(
            .TIME_BITS (TIME_BITS)
        ) u_deb (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_advance),
            .i_raw    (r_in_levels[g]),
            .i_now    (r_in_now[TIME_BITS-1:0]),
            .i_delay  (r_debounce_delay),
            .o_status (w_status[g])
        );
        assign w_stable[g] = w_status[g].stable;
        assign w_press[g]  = w_status[g].press;
    end

    // Both adjust presses of one scan saturate once on the combined sum.
    assign w_step_hm = {1'b0, r_hour_step} + {1'b0, r_minute_step};
    assign w_sum_h   = {1'b0, r_preset} + (bdmc_pkg::PRESET_W+1)'(r_hour_step);
    assign w_sum_m   = {1'b0, r_preset} + (bdmc_pkg::PRESET_W+1)'(r_minute_step);
    assign w_sum_hm  = {1'b0, r_preset} + (bdmc_pkg::PRESET_W+1)'(w_step_hm);
    assign w_sat_h   = w_sum_h[bdmc_pkg::PRESET_W]  ? '1 : w_sum_h[bdmc_pkg::PRESET_W-1:0];
    assign w_sat_m   = w_sum_m[bdmc_pkg::PRESET_W]  ? '1 : w_sum_m[bdmc_pkg::PRESET_W-1:0];
    assign w_sat_hm  = w_sum_hm[bdmc_pkg::PRESET_W] ? '1 : w_sum_hm[bdmc_pkg::PRESET_W-1:0];

    always_comb begin
        n_pending = r_pending | w_press;
        n_cook    = r_cook;
        n_warm    = r_warm;
        n_adjust  = r_adjust;
        n_menu    = r_menu;
        n_preset  = r_preset;

        if (n_pending[bdmc_pkg::BTN_ADJUST]) begin
            n_adjust = !r_adjust;
            n_pending[bdmc_pkg::BTN_ADJUST] = 1'b0;
        end else if (n_pending[bdmc_pkg::BTN_COOK]) begin
            n_cook = 1'b1;
            n_warm = 1'b0;
            n_pending[bdmc_pkg::BTN_COOK] = 1'b0;
        end else if (n_pending[bdmc_pkg::BTN_WARM]) begin
            if (r_cook) begin
                n_cook = 1'b0;
            end else if (r_warm) begin
                n_warm = 1'b0;
            end else begin
                n_warm = 1'b1;
            end
            n_pending[bdmc_pkg::BTN_WARM] = 1'b0;
        end else if (n_pending[bdmc_pkg::BTN_MENU]) begin
            n_menu = (r_menu < r_menu_top) ? r_menu + 1'b1 : '0;
            n_pending[bdmc_pkg::BTN_MENU] = 1'b0;
        end

        if (n_adjust) begin
            n_cook = 1'b0;
            n_warm = 1'b0;
            if (n_pending[bdmc_pkg::BTN_HOUR] && n_pending[bdmc_pkg::BTN_MINUTE]) begin
                n_preset = w_sat_hm;
            end else if (n_pending[bdmc_pkg::BTN_HOUR]) begin
                n_preset = w_sat_h;
            end else if (n_pending[bdmc_pkg::BTN_MINUTE]) begin
                n_preset = w_sat_m;
            end
            n_pending[bdmc_pkg::BTN_HOUR]   = 1'b0;
            n_pending[bdmc_pkg::BTN_MINUTE] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_cook    <= 1'b0;
            r_warm    <= 1'b0;
            r_adjust  <= 1'b0;
            r_menu    <= '0;
            r_preset  <= '0;
        end else if (w_advance) begin
            r_pending <= n_pending;
            r_cook    <= n_cook;
            r_warm    <= n_warm;
            r_adjust  <= n_adjust;
            r_menu    <= n_menu;
            r_preset  <= n_preset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {3'b000, w_stable, n_preset, n_menu, n_adjust, n_warm, n_cook};
        end
    end

endmodule

`default_nettype wire

>>> rtl/bdmc_checker.sv
// ----------------------------------------------------------------------------
// bdmc_checker
// Port-level checks of the button debounce and mode control block.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [bdmc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Cooking, warming and adjust are mutually exclusive.
    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[2:0]) <= 1)
        else $error("more than one mode active");

    // The preset time never decreases between consecutive results.
    a_preset_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) ##1 m_axis_tvalid
        |-> m_axis_tdata[38:7] >= $past(m_axis_tdata[38:7]))
        else $error("preset time decreased");

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind button_debounce_mode_control bdmc_checker u_bdmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/button_debounce_mode_control_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_mode_control_tb
// Self-checking testbench for the six-button debouncer with mode control.
// Scans go in on the input stream with a millisecond time that the bench
// controls, and an internal model predicts the debounced levels, modes, menu
// and preset time of every scan. Directed scans cover debounce timing, time
// wrap, bounces and press priority. Random press sequences then run under
// several register settings and flow-control patterns. A run of hour and
// minute presses in adjust mode checks the preset time steps.
// ----------------------------------------------------------------------------
module button_debounce_mode_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [5:0] ALL_RELEASED = 6'h3f;
    localparam logic [5:0] WARM_BIT     = 6'd1 << bdmc_pkg::BTN_WARM;
    localparam logic [5:0] COOK_BIT     = 6'd1 << bdmc_pkg::BTN_COOK;
    localparam logic [5:0] ADJUST_BIT   = 6'd1 << bdmc_pkg::BTN_ADJUST;
    localparam logic [5:0] HOUR_BIT     = 6'd1 << bdmc_pkg::BTN_HOUR;
    localparam logic [5:0] MINUTE_BIT   = 6'd1 << bdmc_pkg::BTN_MINUTE;

    typedef struct packed {
        logic [5:0]  stable;
        logic [31:0] preset;
        logic [3:0]  menu;
        logic        adjust;
        logic        warming;
        logic        cooking;
    } t_scan_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [bdmc_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [bdmc_pkg::CFG_DATA_W-1:0]      i_cfg_data;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    // [5:0] button_levels, [37:6] now_ms, [39:38] zero
    logic [bdmc_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    // [0] cooking_on, [1] warming_on, [2] adjust_on, [6:3] menu_number,
    // [38:7] preset_seconds, [44:39] stable_levels, [47:45] zero
    logic [bdmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;

    button_debounce_mode_control u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Model state and configuration.
    logic [5:0]   stable_q;
    logic [5:0]   prev_raw_q;
    logic [5:0]   pending_q;
    logic [31:0]  stamp_q [6];
    logic         cooking_q;
    logic         warming_q;
    logic         adjust_q;
    logic [3:0]   menu_q;
    logic [31:0]  preset_q;
    logic [15:0]  delay_cfg;
    logic [3:0]   menu_top_cfg;
    logic [15:0]  hour_step_cfg;
    logic [15:0]  minute_step_cfg;

    t_scan_result expected_panel_q[$];
    t_scan_result checker_want;
    t_scan_result checker_got;

    logic [31:0]  clock_ms;
    logic [5:0]   raw_levels_sent;
    int           send_idle_pct;
    int           ready_stall_pct;
    int           mismatch_count;
    int           results_checked;
    int           scans_sent;
    int           reg_writes;
    int           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (ready_stall_pct == 0) || ($urandom_range(99) >= ready_stall_pct);
    end

    function automatic logic [31:0] saturating_sum(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    task automatic reset_panel_model();
        stable_q        = ALL_RELEASED;
        prev_raw_q      = ALL_RELEASED;
        pending_q       = '0;
        for (int b = 0; b < bdmc_pkg::BUTTON_COUNT; b++) stamp_q[b] = '0;
        cooking_q       = 1'b0;
        warming_q       = 1'b0;
        adjust_q        = 1'b0;
        menu_q          = '0;
        preset_q        = '0;
        delay_cfg       = bdmc_pkg::DEBOUNCE_DELAY_RESET;
        menu_top_cfg    = bdmc_pkg::MENU_TOP_RESET;
        hour_step_cfg   = bdmc_pkg::HOUR_STEP_RESET;
        minute_step_cfg = bdmc_pkg::MINUTE_STEP_RESET;
    endtask

    task automatic predict_panel_state(input logic [5:0] levels, input logic [31:0] now_ms,
                                       output t_scan_result res);
        logic [31:0] elapsed;
        for (int b = 0; b < bdmc_pkg::BUTTON_COUNT; b++) begin
            if (levels[b] != prev_raw_q[b]) stamp_q[b] = now_ms;
            elapsed = now_ms - stamp_q[b];
            if (elapsed > {16'd0, delay_cfg} && levels[b] != stable_q[b]) begin
                stable_q[b] = levels[b];
                if (!levels[b]) pending_q[b] = 1'b1;
            end
        end
        if (pending_q[bdmc_pkg::BTN_ADJUST]) begin
            adjust_q = !adjust_q;
            pending_q[bdmc_pkg::BTN_ADJUST] = 1'b0;
        end else if (pending_q[bdmc_pkg::BTN_COOK]) begin
            cooking_q = 1'b1;
            warming_q = 1'b0;
            pending_q[bdmc_pkg::BTN_COOK] = 1'b0;
        end else if (pending_q[bdmc_pkg::BTN_WARM]) begin
            if (cooking_q) cooking_q = 1'b0;
            else if (warming_q) warming_q = 1'b0;
            else warming_q = 1'b1;
            pending_q[bdmc_pkg::BTN_WARM] = 1'b0;
        end else if (pending_q[bdmc_pkg::BTN_MENU]) begin
            menu_q = (menu_q < menu_top_cfg) ? menu_q + 4'd1 : 4'd0;
            pending_q[bdmc_pkg::BTN_MENU] = 1'b0;
        end
        if (adjust_q) begin
            cooking_q = 1'b0;
            warming_q = 1'b0;
            if (pending_q[bdmc_pkg::BTN_HOUR]) begin
                preset_q = saturating_sum(preset_q, hour_step_cfg);
                pending_q[bdmc_pkg::BTN_HOUR] = 1'b0;
            end
            if (pending_q[bdmc_pkg::BTN_MINUTE]) begin
                preset_q = saturating_sum(preset_q, minute_step_cfg);
                pending_q[bdmc_pkg::BTN_MINUTE] = 1'b0;
            end
        end
        prev_raw_q  = levels;
        res.stable  = stable_q;
        res.preset  = preset_q;
        res.menu    = menu_q;
        res.adjust  = adjust_q;
        res.warming = warming_q;
        res.cooking = cooking_q;
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_panel_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result with no scan pending, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end else begin
                checker_want = expected_panel_q.pop_front();
                checker_got  = t_scan_result'(m_axis_tdata[44:0]);
                check_field("cooking_on", 32'(checker_want.cooking),
                            32'(checker_got.cooking));
                check_field("warming_on", 32'(checker_want.warming),
                            32'(checker_got.warming));
                check_field("adjust_on", 32'(checker_want.adjust),
                            32'(checker_got.adjust));
                check_field("menu_number", 32'(checker_want.menu), 32'(checker_got.menu));
                check_field("preset_seconds", checker_want.preset, checker_got.preset);
                check_field("stable_levels", 32'(checker_want.stable),
                            32'(checker_got.stable));
                check_field("padding", 32'd0,
                            32'(m_axis_tdata[bdmc_pkg::OUT_TDATA_W-1:45]));
                results_checked++;
            end
        end
    end

    task automatic send_scan(input logic [5:0] levels, input logic [31:0] advance);
        t_scan_result predicted;
        clock_ms = clock_ms + advance;
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, clock_ms, levels};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_panel_state(levels, clock_ms, predicted);
        expected_panel_q.push_back(predicted);
        raw_levels_sent = levels;
        scans_sent++;
    endtask

    task automatic tap_buttons(input logic [5:0] mask);
        send_scan(~mask, 1);
        send_scan(~mask, delay_cfg + 1);
        send_scan(ALL_RELEASED, 1);
        send_scan(ALL_RELEASED, delay_cfg + 1);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_panel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input bdmc_pkg::t_cfg_index idx, input logic [15:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            bdmc_pkg::CFG_DEBOUNCE_DELAY: delay_cfg       = value;
            bdmc_pkg::CFG_MENU_TOP:       menu_top_cfg    = value[3:0];
            bdmc_pkg::CFG_HOUR_STEP:      hour_step_cfg   = value;
            bdmc_pkg::CFG_MINUTE_STEP:    minute_step_cfg = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [15:0] dly, input logic [3:0] top,
                             input logic [15:0] hour, input logic [15:0] minute);
        write_reg(bdmc_pkg::CFG_DEBOUNCE_DELAY, dly);
        write_reg(bdmc_pkg::CFG_MENU_TOP, {12'd0, top});
        write_reg(bdmc_pkg::CFG_HOUR_STEP, hour);
        write_reg(bdmc_pkg::CFG_MINUTE_STEP, minute);
    endtask

    task automatic run_random_scans(input int count);
        int         issued;
        int         pick;
        int         shape;
        logic [5:0] target;
        issued = 0;
        while (issued < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                // A level change held past the debounce delay.
                target = raw_levels_sent;
                shape  = $urandom_range(3);
                if (shape == 0) begin
                    target = 6'($urandom_range(63));
                end else begin
                    target[3'($urandom_range(5))] ^= 1'b1;
                    if (shape == 1) target[3'($urandom_range(5))] ^= 1'b1;
                end
                send_scan(target, $urandom_range(3));
                if ($urandom_range(3) == 0) begin
                    send_scan(target, $urandom_range(delay_cfg));
                    issued++;
                end
                send_scan(target, delay_cfg + 1 + $urandom_range(3));
                issued += 2;
            end else if (pick < 90) begin
                send_scan(6'($urandom_range(63)), $urandom_range(delay_cfg));
                issued++;
            end else begin
                clock_ms = $urandom();
                send_scan(6'($urandom_range(63)), 0);
                issued++;
            end
        end
    endtask

    task automatic test_reset_values();
        clock_ms = '0;
        send_scan(ALL_RELEASED, 0);
    endtask

    task automatic test_debounce_timing();
        send_scan(~WARM_BIT, 10);
        send_scan(~WARM_BIT, 50);
        send_scan(~WARM_BIT, 1);
        send_scan(ALL_RELEASED, 1);
        send_scan(~WARM_BIT, 1);
        send_scan(ALL_RELEASED, 0);
        send_scan(ALL_RELEASED, 51);
        clock_ms = 32'hffff_ffe0;
        send_scan(~WARM_BIT, 0);
        send_scan(~WARM_BIT, 64);
        send_scan(ALL_RELEASED, 1);
        send_scan(ALL_RELEASED, 51);
    endtask

    task automatic test_mode_priority();
        send_scan(~(COOK_BIT | WARM_BIT | HOUR_BIT), 1);
        send_scan(~(COOK_BIT | WARM_BIT | HOUR_BIT), 51);
        send_scan(~(COOK_BIT | WARM_BIT | HOUR_BIT), 1);
        send_scan(ALL_RELEASED, 1);
        send_scan(ALL_RELEASED, 51);
        send_scan(6'h00, 1);
        send_scan(6'h00, 51);
        send_scan(6'h00, 1);
        send_scan(6'h00, 1);
        send_scan(6'h00, 1);
        send_scan(ALL_RELEASED, 1);
        send_scan(ALL_RELEASED, 51);
    endtask

    task automatic test_register_settings();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        run_random_scans(200);
        configure(16'd0, 4'd0, 16'd0, 16'd0);
        send_idle_pct = 57;
        run_random_scans(200);
        configure(16'hffff, 4'd15, 16'hffff, 16'hffff);
        send_idle_pct   = 0;
        ready_stall_pct = 57;
        run_random_scans(200);
        configure(16'($urandom_range(200)), 4'($urandom_range(15)),
                  16'($urandom()), 16'($urandom()));
        send_idle_pct   = 22;
        ready_stall_pct = 22;
        run_random_scans(200);
        configure(16'($urandom_range(20)), 4'($urandom_range(15)),
                  16'($urandom()), 16'($urandom()));
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        run_random_scans(200);
    endtask

    task automatic test_preset_adjust();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        configure(16'd0, bdmc_pkg::MENU_TOP_RESET, 16'hffff, 16'hffff);
        send_scan(ALL_RELEASED, 1);
        send_scan(ALL_RELEASED, 1);
        tap_buttons(HOUR_BIT);
        if (!adjust_q) tap_buttons(ADJUST_BIT);
        repeat (8) tap_buttons(HOUR_BIT | MINUTE_BIT);
        tap_buttons(MINUTE_BIT);
        tap_buttons(ADJUST_BIT);
        tap_buttons(HOUR_BIT);
        tap_buttons(ADJUST_BIT);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = bdmc_pkg::CFG_DEBOUNCE_DELAY;
        i_cfg_data      = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b1;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        mismatch_count  = 0;
        results_checked = 0;
        scans_sent      = 0;
        reg_writes      = 0;
        cycle_count     = 0;
        clock_ms        = '0;
        raw_levels_sent = ALL_RELEASED;
        reset_panel_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_debounce_timing();
        test_mode_priority();
        test_register_settings();
        test_preset_adjust();

        settle();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d scans sent, %0d results checked, %0d register writes",
                 scans_sent, results_checked, reg_writes);
        $display("tb: debounce edges, time wrap, press priority, register extremes, %s",
                 "flow-control patterns and preset steps in adjust mode");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
